// ===== sv/rle8_pkg.sv =====
// Shared types and constants of the RLE8 bitmap decoder.
package rle8_pkg;

    localparam int RLE8_MAX_DIM = 4096;

    localparam int CFG_W = 13;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // Codes that follow an escape byte.
    localparam logic [7:0] ESC_BYTE = 8'd0;
    localparam logic [7:0] ESC_END_OF_LINE = 8'd0;
    localparam logic [7:0] ESC_END_OF_BITMAP = 8'd1;
    localparam logic [7:0] ESC_DELTA = 8'd2;

    typedef enum logic [2:0] {
        PH_COUNT,
        PH_INDEX,
        PH_ESCAPE,
        PH_DX,
        PH_DY,
        PH_LITERAL
    } rle8_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } rle8_in_t;

    typedef struct packed {
        logic [11:0] row;
        logic [11:0] column;
        logic [7:0]  run_length;
        logic [7:0]  pixel_index;
        logic        line_end;
        logic        image_end;
        logic        clipped;
    } rle8_out_t;

    // One decode step's result toward the output register.
    typedef struct packed {
        logic      valid;
        rle8_out_t data;
    } rle8_res_t;

endpackage

// ===== sv/rle8_in_stage.sv =====
// Input register that holds one accepted byte until the decoder takes it.
module rle8_in_stage
    import rle8_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  rle8_in_t s_data,
    input  logic     take,
    output logic     held_valid,
    output rle8_in_t held_data
);

    logic     valid_reg;
    logic     valid_next;
    rle8_in_t data_reg;

    // The register frees up in the same cycle the decoder consumes it.
    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign held_valid = valid_reg;
    assign held_data  = data_reg;

endmodule

// ===== sv/rle8_decode.sv =====
// Byte-level RLE8 decode state machine and write descriptor generation.
module rle8_decode
    import rle8_pkg::*;
#(
    parameter int MAX_DIMENSION = RLE8_MAX_DIM
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step,
    input  rle8_in_t in_data,
    input  logic [$clog2(MAX_DIMENSION+1)-1:0] width,
    input  logic [$clog2(MAX_DIMENSION+1)-1:0] height,
    output rle8_res_t res
);

    localparam int DW = $clog2(MAX_DIMENSION + 1);
    localparam int KW = ((DW > 8) ? DW : 8) + 1;
    localparam logic [DW-1:0] MAX_D = DW'(MAX_DIMENSION);

    rle8_phase_t   phase_reg, phase_next, phase_cur;
    logic [7:0]    held_reg, held_next, held_cur;
    logic [7:0]    lit_reg, lit_next, lit_cur;
    logic          pad_reg, pad_next, pad_cur;
    logic [DW-1:0] row_reg, row_next, row_cur;
    logic [DW-1:0] col_reg, col_next, col_cur;
    logic          fin_reg, fin_next, fin_cur;

    logic [7:0]    b;
    logic [7:0]    run_count;
    logic          outside;
    logic [DW-1:0] room;
    logic          cut;
    logic [DW-1:0] top_row;
    logic [DW-1:0] col_after;
    rle8_out_t     run_out;

    // Add a byte to a cursor coordinate, saturating at the largest dimension.
    function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] a, input logic [7:0] d);
        logic [KW-1:0] s;
        s = KW'(a) + KW'(d);
        return (s > KW'(MAX_DIMENSION)) ? MAX_D : s[DW-1:0];
    endfunction

    assign b = in_data.data_byte;

    // A frame start clears the decode state before the byte is decoded.
    always_comb begin
        if (in_data.frame_start) begin
            phase_cur = PH_COUNT;
            held_cur  = '0;
            lit_cur   = '0;
            pad_cur   = 1'b0;
            row_cur   = '0;
            col_cur   = '0;
            fin_cur   = 1'b0;
        end else begin
            phase_cur = phase_reg;
            held_cur  = held_reg;
            lit_cur   = lit_reg;
            pad_cur   = pad_reg;
            row_cur   = row_reg;
            col_cur   = col_reg;
            fin_cur   = fin_reg;
        end
    end

    // Descriptor for a fill run or a single literal at the current cursor.
    assign run_count = (phase_cur == PH_INDEX) ? held_cur : 8'd1;
    assign outside   = (row_cur >= height) || (col_cur >= width);
    assign room      = width - col_cur;
    assign cut       = KW'(run_count) > KW'(room);
    assign top_row   = height - DW'(1) - row_cur;
    assign col_after = sat_add(col_cur, run_count);

    always_comb begin
        run_out = '0;
        run_out.pixel_index = b;
        if (outside) begin
            run_out.clipped = 1'b1;
        end else begin
            run_out.row        = 12'(top_row);
            run_out.column     = 12'(col_cur);
            run_out.run_length = cut ? 8'(room) : run_count;
            run_out.clipped    = cut;
        end
    end

    always_comb begin
        phase_next = phase_cur;
        held_next  = held_cur;
        lit_next   = lit_cur;
        pad_next   = pad_cur;
        row_next   = row_cur;
        col_next   = col_cur;
        fin_next   = fin_cur;
        res        = '0;
        if (!fin_cur) begin
            case (phase_cur)
                PH_COUNT: begin
                    if (b == ESC_BYTE) begin
                        phase_next = PH_ESCAPE;
                    end else begin
                        held_next  = b;
                        phase_next = PH_INDEX;
                    end
                end
                PH_INDEX: begin
                    res.valid  = 1'b1;
                    res.data   = run_out;
                    col_next   = col_after;
                    held_next  = '0;
                    phase_next = PH_COUNT;
                end
                PH_ESCAPE: begin
                    case (b)
                        ESC_END_OF_LINE: begin
                            res.valid         = 1'b1;
                            res.data.line_end = 1'b1;
                            row_next          = sat_add(row_cur, 8'd1);
                            col_next          = '0;
                            phase_next        = PH_COUNT;
                        end
                        ESC_END_OF_BITMAP: begin
                            res.valid          = 1'b1;
                            res.data.image_end = 1'b1;
                            fin_next           = 1'b1;
                            phase_next         = PH_COUNT;
                        end
                        ESC_DELTA: begin
                            phase_next = PH_DX;
                        end
                        default: begin
                            lit_next   = b;
                            pad_next   = b[0];
                            phase_next = PH_LITERAL;
                        end
                    endcase
                end
                PH_DX: begin
                    held_next  = b;
                    phase_next = PH_DY;
                end
                PH_DY: begin
                    col_next   = sat_add(col_cur, held_cur);
                    row_next   = sat_add(row_cur, b);
                    held_next  = '0;
                    phase_next = PH_COUNT;
                end
                PH_LITERAL: begin
                    if (lit_cur == 8'd0) begin
                        // This byte is the pad after an odd literal count.
                        pad_next   = 1'b0;
                        phase_next = PH_COUNT;
                    end else begin
                        res.valid = 1'b1;
                        res.data  = run_out;
                        col_next  = col_after;
                        lit_next  = lit_cur - 8'd1;
                        if (lit_cur == 8'd1 && !pad_cur) begin
                            phase_next = PH_COUNT;
                        end
                    end
                end
                default: begin
                    phase_next = PH_COUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_COUNT;
            held_reg  <= '0;
            lit_reg   <= '0;
            pad_reg   <= 1'b0;
            row_reg   <= '0;
            col_reg   <= '0;
            fin_reg   <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            lit_reg   <= lit_next;
            pad_reg   <= pad_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

// ===== sv/rle8_out_stage.sv =====
// Output register that holds one write descriptor until it is taken.
module rle8_out_stage
    import rle8_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  rle8_res_t res,
    output logic      m_valid,
    input  logic      m_ready,
    output rle8_out_t m_data
);

    logic      valid_reg;
    logic      valid_next;
    rle8_out_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = res.valid;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && res.valid) begin
            data_reg <= res.data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ===== sv/rle8_bitmap_decoder.sv =====
// Top level of the RLE8 bitmap decoder: configuration, input and output registers.
// A byte accepted into the input register is decoded once the output register is free,
// and any write descriptor it yields is registered in the output register, raising m_valid.
// Throughput: one byte per cycle; the input only stalls while a byte is held and a
// result waits in the output register with m_ready low.
// Reset (aresetn low, synchronous): decode state, cursor and valid flags clear,
// and both image dimensions return to one.
module rle8_bitmap_decoder
    import rle8_pkg::*;
#(
    parameter int MAX_DIMENSION = RLE8_MAX_DIM
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rle8_in_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rle8_out_t            m_data
);

    // Cursor coordinates and dimensions must be able to hold MAX_DIMENSION itself.
    localparam int DW = $clog2(MAX_DIMENSION + 1);
    localparam int CW = (DW > CFG_W) ? DW : CFG_W;

    logic [DW-1:0] width_reg;
    logic [DW-1:0] width_next;
    logic [DW-1:0] height_reg;
    logic [DW-1:0] height_next;
    logic [DW-1:0] cfg_clamped;

    logic      held_valid;
    rle8_in_t  held_data;
    logic      step;
    rle8_res_t res;

    // The dimensions are clamped to 1..MAX_DIMENSION once, when they are written,
    // so the decode path only sees legal values.
    always_comb begin
        if (cfg_data == '0) begin
            cfg_clamped = DW'(1);
        end else if (CW'(cfg_data) > CW'(MAX_DIMENSION)) begin
            cfg_clamped = DW'(MAX_DIMENSION);
        end else begin
            cfg_clamped = DW'(cfg_data);
        end
    end

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_next = cfg_clamped;
                REG_IMAGE_HEIGHT: height_next = cfg_clamped;
                default: begin
                    width_next  = width_reg;
                    height_next = height_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DW'(1);
            height_reg <= DW'(1);
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // A held byte is decoded whenever the output register is empty or being
    // drained this cycle. Bytes that make no result still advance the state.
    assign step = held_valid && (!m_valid || m_ready);

    rle8_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (step),
        .held_valid (held_valid),
        .held_data  (held_data)
    );

    rle8_decode #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_data (held_data),
        .width   (width_reg),
        .height  (height_reg),
        .res     (res)
    );

    // The output register loads on every decode step; a step without a result
    // empties it, which is safe because a step only happens when it is free.
    rle8_out_stage u_out_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (step),
        .res     (res),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== sv/rle8_checker.sv =====
// Port-level checks on the RLE8 decoder's result channel, bound to the top level.
module rle8_checker
    import rle8_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input rle8_out_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result request changed while stalled");

    a_marker_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.line_end || m_data.image_end) |->
            m_data.run_length == 8'd0 && m_data.row == 12'd0 &&
            m_data.column == 12'd0 && !m_data.clipped && m_data.pixel_index == 8'd0)
        else $error("marker result carries a payload");

    a_one_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.line_end && m_data.image_end))
        else $error("end of line and end of bitmap in one result");

    a_empty_run_clipped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.line_end && !m_data.image_end && m_data.run_length == 8'd0
            |-> m_data.clipped && m_data.row == 12'd0 && m_data.column == 12'd0)
        else $error("empty run not reported as clipped");

endmodule

bind rle8_bitmap_decoder rle8_checker u_rle8_checker (.*);
